/* sv/lrc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared constants, codes and item types of the LRU record cache tag store.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int RANK_W  = IDX_W;
  localparam int LIM_W   = (CNT_W > 5) ? CNT_W : 5;
  localparam int KEY_W   = 64;
  localparam int SLOT_W  = 4;
  localparam int CFG_W   = 5;

  typedef enum logic [1:0] {
    FUNC_ACCESS = 2'd0,
    FUNC_INVAL  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_HIT,
    OP_INSERT,
    OP_DROP,
    OP_CLEAR
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
    logic             decrypt_ok;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              inserted;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } rsp_t;

endpackage
`default_nettype wire

/* sv/lrc_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lrc_req_if / lrc_rsp_if
// Valid/ready channels carrying request and result items of the tag store.
// ----------------------------------------------------------------------------
interface lrc_req_if;
  logic          valid;
  logic          ready;
  lrc_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrc_rsp_if;
  logic          valid;
  logic          ready;
  lrc_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/lru_record_cache_tags.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lru_record_cache_tags
// Fully associative 64-bit tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Tags and recency ranks live in two synchronous memories with one read and
// one write port each; valid bits and the live count are flops. One item is
// handled at a time. An access or invalidate sweeps both memories once to
// find the key, the least recent entry and its tag, then, when ranks change,
// sweeps the rank memory again to read-modify-write every rank. A clear or
// reserved code skips both sweeps and goes straight to the finish state. The
// result waits in an output register, so a new item is taken while the
// previous result is still pending.
// ----------------------------------------------------------------------------
module lru_record_cache_tags (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire [lrc_pkg::CFG_W-1:0]  cfg_wdata_i,
  lrc_req_if.sink                   req_i,
  lrc_rsp_if.source                 rsp_o
);

  localparam int N = lrc_pkg::ENTRIES;
  localparam int IW = lrc_pkg::IDX_W;
  localparam int CW = lrc_pkg::CNT_W;
  localparam int RW = lrc_pkg::RANK_W;
  localparam int LW = lrc_pkg::LIM_W;
  localparam int XW = (IW > lrc_pkg::SLOT_W) ? IW : lrc_pkg::SLOT_W;
  localparam int CFG_W_L = lrc_pkg::CFG_W;

  // memories
  logic [lrc_pkg::KEY_W-1:0] tag_mem  [N];
  logic [RW-1:0]             rank_mem [N];
  logic [lrc_pkg::KEY_W-1:0] tag_rd_q;
  logic [RW-1:0]             rank_rd_q;

  lrc_pkg::state_e state_q, state_d;
  lrc_pkg::op_e    op_q;

  logic [CFG_W_L-1:0] cfg_q;

  logic [N-1:0]  valid_q;
  logic [CW-1:0] live_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] rd_idx_q;

  logic [1:0]                func_q;
  logic [lrc_pkg::KEY_W-1:0] key_q;
  logic                      ok_q;

  logic                      hit_q;
  logic [IW-1:0]             hit_idx_q;
  logic [RW-1:0]             hit_rank_q;
  logic                      old_found_q;
  logic [IW-1:0]             old_idx_q;
  logic [RW-1:0]             old_rank_q;
  logic [lrc_pkg::KEY_W-1:0] old_tag_q;
  logic                      evict_q;
  logic [IW-1:0]             ins_idx_q;

  lrc_pkg::rsp_t out_q;
  logic          out_valid_q;

  // combinational
  logic          sweep_last;
  logic          data_vld;
  logic          cur_valid;
  logic [LW-1:0] lim;
  logic          evict_now;
  logic [N-1:0]  free_mask;
  logic [IW-1:0] free_idx;
  logic [RW-1:0] rank_new;
  logic          rank_we;
  logic          req_ready;
  logic          finish_go;
  lrc_pkg::rsp_t rsp_next;
  logic [XW-1:0] slot_ext;

  assign sweep_last = (cnt_q == CW'(N));
  assign data_vld   = (cnt_q != '0);
  assign cur_valid  = valid_q[rd_idx_q];

  // effective limit: zero acts as one, above the depth acts as the depth
  always_comb begin
    if (cfg_q == '0) begin
      lim = LW'(1);
    end else if (LW'(cfg_q) > LW'(N)) begin
      lim = LW'(N);
    end else begin
      lim = LW'(cfg_q);
    end
  end

  assign evict_now = (LW'(live_q) >= lim) && old_found_q;

  // lowest free slot, with the victim already dropped
  always_comb begin
    free_mask = ~valid_q;
    if (evict_now) begin
      free_mask[old_idx_q] = 1'b1;
    end
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // new rank for the entry whose data is present in the update sweep
  always_comb begin
    rank_new = rank_rd_q;
    case (op_q)
      lrc_pkg::OP_HIT: begin
        if (rd_idx_q == hit_idx_q) begin
          rank_new = '0;
        end else if (cur_valid && (rank_rd_q < hit_rank_q)) begin
          rank_new = rank_rd_q + RW'(1);
        end
      end
      lrc_pkg::OP_INSERT: begin
        if (rd_idx_q == ins_idx_q) begin
          rank_new = '0;
        end else if (cur_valid && !(evict_q && (rd_idx_q == old_idx_q))) begin
          // a rank above the victim drops by one, then all rise by one
          if (!(evict_q && (rank_rd_q > old_rank_q))) begin
            rank_new = rank_rd_q + RW'(1);
          end
        end
      end
      lrc_pkg::OP_DROP: begin
        if (cur_valid && (rd_idx_q != hit_idx_q) && (rank_rd_q > hit_rank_q)) begin
          rank_new = rank_rd_q - RW'(1);
        end
      end
      default: rank_new = rank_rd_q;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lrc_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          if (lrc_pkg::func_e'(req_i.data.func) == lrc_pkg::FUNC_ACCESS ||
              lrc_pkg::func_e'(req_i.data.func) == lrc_pkg::FUNC_INVAL) begin
            state_d = lrc_pkg::ST_SEARCH;
          end else begin
            state_d = lrc_pkg::ST_FINISH;
          end
        end
      end
      lrc_pkg::ST_SEARCH: begin
        if (sweep_last) state_d = lrc_pkg::ST_DECIDE;
      end
      lrc_pkg::ST_DECIDE: begin
        if (lrc_pkg::func_e'(func_q) == lrc_pkg::FUNC_ACCESS && (hit_q || ok_q)) begin
          state_d = lrc_pkg::ST_UPDATE;
        end else if (lrc_pkg::func_e'(func_q) == lrc_pkg::FUNC_INVAL && hit_q) begin
          state_d = lrc_pkg::ST_UPDATE;
        end else begin
          state_d = lrc_pkg::ST_FINISH;
        end
      end
      lrc_pkg::ST_UPDATE: begin
        if (sweep_last) state_d = lrc_pkg::ST_FINISH;
      end
      lrc_pkg::ST_FINISH: begin
        if (finish_go) state_d = lrc_pkg::ST_IDLE;
      end
      default: state_d = lrc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_ready = 1'b0;
    rank_we   = 1'b0;
    finish_go = 1'b0;
    case (state_q)
      lrc_pkg::ST_IDLE:   req_ready = 1'b1;
      lrc_pkg::ST_UPDATE: rank_we   = data_vld;
      lrc_pkg::ST_FINISH: finish_go = !out_valid_q || rsp_o.ready;
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign req_i.ready = req_ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  // result of the finished item
  always_comb begin
    rsp_next = '0;
    case (op_q)
      lrc_pkg::OP_HIT, lrc_pkg::OP_DROP: begin
        slot_ext      = XW'(hit_idx_q);
        rsp_next.hit  = 1'b1;
        rsp_next.slot = slot_ext[lrc_pkg::SLOT_W-1:0];
      end
      lrc_pkg::OP_INSERT: begin
        slot_ext          = XW'(ins_idx_q);
        rsp_next.inserted = 1'b1;
        rsp_next.slot     = slot_ext[lrc_pkg::SLOT_W-1:0];
        rsp_next.evicted  = evict_q;
        if (evict_q) rsp_next.evicted_key = old_tag_q;
      end
      default: slot_ext = '0;
    endcase
  end

  // memories: registered reads, writes by the sequencer
  always_ff @(posedge clk_i) begin
    tag_rd_q  <= tag_mem[cnt_q[IW-1:0]];
    rank_rd_q <= rank_mem[cnt_q[IW-1:0]];
    if (rank_we) begin
      rank_mem[rd_idx_q] <= rank_new;
    end
    if (state_q == lrc_pkg::ST_DECIDE && lrc_pkg::func_e'(func_q) == lrc_pkg::FUNC_ACCESS
        && !hit_q && ok_q) begin
      tag_mem[free_idx] <= key_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lrc_pkg::ST_IDLE;
      cfg_q       <= CFG_W_L'(N > 16 ? 16 : N);
      valid_q     <= '0;
      live_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      op_q        <= lrc_pkg::OP_NONE;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;

      if (state_q == lrc_pkg::ST_SEARCH || state_q == lrc_pkg::ST_UPDATE) begin
        cnt_q <= sweep_last ? '0 : cnt_q + CW'(1);
      end

      if (rsp_o.ready && !finish_go) out_valid_q <= 1'b0;

      case (state_q)
        lrc_pkg::ST_IDLE: begin
          if (req_i.valid) begin
            cnt_q <= '0;
            if (lrc_pkg::func_e'(req_i.data.func) == lrc_pkg::FUNC_CLEAR) begin
              op_q <= lrc_pkg::OP_CLEAR;
            end else begin
              op_q <= lrc_pkg::OP_NONE;
            end
          end
        end
        lrc_pkg::ST_DECIDE: begin
          if (lrc_pkg::func_e'(func_q) == lrc_pkg::FUNC_ACCESS) begin
            if (hit_q) begin
              op_q <= lrc_pkg::OP_HIT;
            end else if (ok_q) begin
              op_q <= lrc_pkg::OP_INSERT;
            end
          end else if (hit_q) begin
            op_q <= lrc_pkg::OP_DROP;
          end
        end
        lrc_pkg::ST_FINISH: begin
          if (finish_go) begin
            out_valid_q <= 1'b1;
            case (op_q)
              lrc_pkg::OP_INSERT: begin
                valid_q[ins_idx_q] <= 1'b1;
                if (evict_q) begin
                  if (old_idx_q != ins_idx_q) valid_q[old_idx_q] <= 1'b0;
                end else begin
                  live_q <= live_q + CW'(1);
                end
              end
              lrc_pkg::OP_DROP: begin
                valid_q[hit_idx_q] <= 1'b0;
                live_q             <= live_q - CW'(1);
              end
              lrc_pkg::OP_CLEAR: begin
                valid_q <= '0;
                live_q  <= '0;
              end
              default: begin
                live_q <= live_q;
              end
            endcase
          end
        end
        default: begin
          op_q <= op_q;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IW-1:0];
    if (finish_go) out_q <= rsp_next;

    case (state_q)
      lrc_pkg::ST_IDLE: begin
        func_q      <= req_i.data.func;
        key_q       <= req_i.data.key;
        ok_q        <= req_i.data.decrypt_ok;
        hit_q       <= 1'b0;
        old_found_q <= 1'b0;
      end
      lrc_pkg::ST_SEARCH: begin
        if (data_vld && cur_valid) begin
          if (tag_rd_q == key_q) begin
            hit_q      <= 1'b1;
            hit_idx_q  <= rd_idx_q;
            hit_rank_q <= rank_rd_q;
          end
          // track the least recent live entry
          if (!old_found_q || (rank_rd_q > old_rank_q)) begin
            old_found_q <= 1'b1;
            old_idx_q   <= rd_idx_q;
            old_rank_q  <= rank_rd_q;
            old_tag_q   <= tag_rd_q;
          end
        end
      end
      lrc_pkg::ST_DECIDE: begin
        evict_q   <= evict_now;
        ins_idx_q <= free_idx;
      end
      default: begin
        ok_q <= ok_q;
      end
    endcase
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU record cache tag store. Requests go in as
// bursts with random gaps while the result side stalls on its own pattern. A
// scoreboard keeps its own copy of tags, valid bits, recency ranks and the
// cache limit, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PHASE_ITEMS = 186;
  localparam int POOL_MAX    = 24;
  localparam int DRAIN_LIMIT = 20000;

  class tag_store_sb;
    logic [lrc_pkg::KEY_W-1:0]  tag_q [lrc_pkg::ENTRIES];
    logic                       valid_q [lrc_pkg::ENTRIES];
    logic [lrc_pkg::RANK_W-1:0] rank_q [lrc_pkg::ENTRIES];
    int unsigned                live_cnt;
    logic [lrc_pkg::CFG_W-1:0]  cache_limit;
    lrc_pkg::rsp_t              expected_rsps [$];
    int                         failures;

    function new();
      foreach (valid_q[i]) begin
        tag_q[i]   = '0;
        valid_q[i] = 1'b0;
        rank_q[i]  = '0;
      end
      live_cnt    = 0;
      cache_limit = lrc_pkg::CFG_W'(16);
      failures    = 0;
    endfunction

    function void set_limit(logic [lrc_pkg::CFG_W-1:0] value);
      cache_limit = value;
    endfunction

    function int find_tag(logic [lrc_pkg::KEY_W-1:0] key);
      int s;
      s = -1;
      for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
        if (s < 0 && valid_q[i] && tag_q[i] == key) s = i;
      end
      return s;
    endfunction

    // Close the rank gap left by the dropped entry.
    function void drop_entry(int s);
      logic [lrc_pkg::RANK_W-1:0] r;
      r = rank_q[s];
      for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
        if (valid_q[i] && i != s && rank_q[i] > r) rank_q[i]--;
      end
      valid_q[s] = 1'b0;
      rank_q[s]  = '0;
      if (live_cnt > 0) live_cnt--;
    endfunction

    function lrc_pkg::rsp_t predict_rsp(lrc_pkg::req_t r);
      lrc_pkg::rsp_t              o;
      int                         s;
      int                         old;
      int                         lim;
      logic [lrc_pkg::RANK_W-1:0] rk;
      o = '0;
      case (lrc_pkg::func_e'(r.func))
        lrc_pkg::FUNC_ACCESS: begin
          s = find_tag(r.key);
          if (s >= 0) begin
            rk = rank_q[s];
            for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
              if (valid_q[i] && rank_q[i] < rk) rank_q[i]++;
            end
            rank_q[s] = '0;
            o.hit  = 1'b1;
            o.slot = lrc_pkg::SLOT_W'(s);
          end else if (r.decrypt_ok) begin
            lim = int'(cache_limit);
            if (lim < 1) lim = 1;
            if (lim > lrc_pkg::ENTRIES) lim = lrc_pkg::ENTRIES;
            if (live_cnt >= lim) begin
              old = -1;
              for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
                if (valid_q[i] && (old < 0 || rank_q[i] > rank_q[old])) old = i;
              end
              if (old >= 0) begin
                o.evicted     = 1'b1;
                o.evicted_key = tag_q[old];
                drop_entry(old);
              end
            end
            // Take the lowest-numbered free slot.
            s = -1;
            for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
              if (s < 0 && !valid_q[i]) s = i;
            end
            if (s >= 0) begin
              for (int i = 0; i < lrc_pkg::ENTRIES; i++) begin
                if (valid_q[i]) rank_q[i]++;
              end
              tag_q[s]   = r.key;
              valid_q[s] = 1'b1;
              rank_q[s]  = '0;
              live_cnt++;
              o.inserted = 1'b1;
              o.slot     = lrc_pkg::SLOT_W'(s);
            end
          end
        end
        lrc_pkg::FUNC_INVAL: begin
          s = find_tag(r.key);
          if (s >= 0) begin
            drop_entry(s);
            o.hit  = 1'b1;
            o.slot = lrc_pkg::SLOT_W'(s);
          end
        end
        lrc_pkg::FUNC_CLEAR: begin
          foreach (valid_q[i]) begin
            valid_q[i] = 1'b0;
            rank_q[i]  = '0;
          end
          live_cnt = 0;
        end
        default: begin
        end
      endcase
      return o;
    endfunction

    function void note_request(lrc_pkg::req_t r);
      expected_rsps.push_back(predict_rsp(r));
    endfunction

    function void check_result(lrc_pkg::rsp_t got);
      lrc_pkg::rsp_t want;
      if (expected_rsps.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: hit=%0b slot=%0d ins=%0b ev=%0b evkey=%h",
                   got.hit, got.slot, got.inserted, got.evicted, got.evicted_key);
        return;
      end
      want = expected_rsps.pop_front();
      if (got.hit !== want.hit || got.slot !== want.slot ||
          got.inserted !== want.inserted || got.evicted !== want.evicted ||
          got.evicted_key !== want.evicted_key) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch exp: hit=%0b slot=%0d ins=%0b ev=%0b evkey=%h",
                   want.hit, want.slot, want.inserted, want.evicted, want.evicted_key);
          $display("         got: hit=%0b slot=%0d ins=%0b ev=%0b evkey=%h",
                   got.hit, got.slot, got.inserted, got.evicted, got.evicted_key);
        end
      end
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction

    function void count_leftover();
      if (expected_rsps.size() != 0) begin
        $display("%0d results never arrived", expected_rsps.size());
        failures += expected_rsps.size();
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [lrc_pkg::CFG_W-1:0] cfg_wdata;

  lrc_req_if req_if ();
  lrc_rsp_if rsp_if ();

  tag_store_sb sb = new();

  logic [lrc_pkg::KEY_W-1:0] key_pool [POOL_MAX];
  int                        pool_n;
  int                        burst_left = 0;

  always #1 clk = ~clk;

  lru_record_cache_tags i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Monitor both channels on pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready) sb.note_request(req_if.data);
      if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
    end
  end

  // Result side: switch between random stall patterns.
  initial begin
    int mode;
    int left;
    int k;
    rsp_if.ready <= 1'b0;
    mode = 0;
    left = 0;
    k    = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
      end
      left--;
      k++;
      case (mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
        2:       rsp_if.ready <= ((k % 7) >= 3);
        default: rsp_if.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  task automatic send_item(input lrc_pkg::req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 8);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    // Hold the item until the block takes it.
    do @(posedge clk); while (!req_if.ready);
    burst_left--;
  endtask

  task automatic send_req(input lrc_pkg::func_e f,
                          input logic [lrc_pkg::KEY_W-1:0] key,
                          input logic ok);
    lrc_pkg::req_t r;
    r.func       = f;
    r.key        = key;
    r.decrypt_ok = ok;
    send_item(r);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_idle();
    int n;
    req_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    n = 0;
    while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cache_limit(input logic [lrc_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_limit(value);
    @(posedge clk);
  endtask

  initial begin
    int            phase_limits [7];
    lrc_pkg::req_t r;
    int            pick;
    logic [63:0]   k64;
    phase_limits = '{31, 0, 1, 17, 16, 2, 0};
    phase_limits[6] = $urandom_range(0, 31);
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset limit, miss without decrypt, inserts, hit, invalidates.
    send_req(lrc_pkg::FUNC_ACCESS, 64'h0, 1'b0);
    send_req(lrc_pkg::FUNC_ACCESS, 64'h0, 1'b1);
    send_req(lrc_pkg::FUNC_ACCESS, '1, 1'b1);
    send_req(lrc_pkg::FUNC_ACCESS, 64'h5555_5555_5555_5555, 1'b1);
    send_req(lrc_pkg::FUNC_ACCESS, 64'h0, 1'b0);
    send_req(lrc_pkg::FUNC_INVAL, '1, 1'b1);
    send_req(lrc_pkg::FUNC_INVAL, 64'h1234_5678_9abc_def0, 1'b0);
    // Freed slot in the middle is reused first.
    send_req(lrc_pkg::FUNC_ACCESS, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    send_req(lrc_pkg::FUNC_RSVD, '1, 1'b1);
    send_req(lrc_pkg::FUNC_ACCESS, 64'h8000_0000_0000_0001, 1'b1);

    // Limit below the live count: one eviction per insert.
    set_cache_limit(lrc_pkg::CFG_W'(2));
    send_req(lrc_pkg::FUNC_ACCESS, 64'hf0f0_f0f0_f0f0_f0f0, 1'b1);
    send_req(lrc_pkg::FUNC_ACCESS, 64'h0f0f_0f0f_0f0f_0f0f, 1'b1);

    // Zero limit behaves as one.
    set_cache_limit(lrc_pkg::CFG_W'(0));
    send_req(lrc_pkg::FUNC_ACCESS, 64'h1, 1'b1);
    send_req(lrc_pkg::FUNC_ACCESS, 64'h1, 1'b0);
    send_req(lrc_pkg::FUNC_CLEAR, 64'h1, 1'b1);
    send_req(lrc_pkg::FUNC_ACCESS, 64'h0, 1'b1);
    send_req(lrc_pkg::FUNC_ACCESS, 64'h2, 1'b1);

    for (int p = 0; p < 7; p++) begin
      set_cache_limit(lrc_pkg::CFG_W'(phase_limits[p]));
      pool_n = $urandom_range(2, POOL_MAX);
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      r.func = lrc_pkg::FUNC_ACCESS;
        else if (pick < 92) r.func = lrc_pkg::FUNC_INVAL;
        else if (pick < 95) r.func = lrc_pkg::FUNC_CLEAR;
        else                r.func = lrc_pkg::FUNC_RSVD;
        if ($urandom_range(0, 99) < 85) k64 = key_pool[$urandom_range(0, pool_n - 1)];
        else                            k64 = {$urandom, $urandom};
        r.key        = k64;
        r.decrypt_ok = ($urandom_range(0, 99) < 85);
        send_item(r);
      end
    end

    wait_idle();
    repeat (60) @(posedge clk);
    sb.count_leftover();
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1200000;
    $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
